FILE: rtl/core/tssg_pkg.sv
// Shared types and constants for the triangle scanline span generator.
// No dependencies.
package tssg_pkg;

   localparam int COORD_BITS_DEFAULT = 12;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   typedef struct packed {
      logic load;      // latch vertices from the request beat
      logic setup;     // pick the two crossing edges of the current row
      logic mul;       // form numerators, start the dividers
      logic step;      // one divider iteration
      logic out_box;   // write bounding box to the result register
      logic out_span;  // write span to the result register, advance row
      logic out_none;  // write an all-zero result
   } cmd_type;

   typedef struct packed {
      logic pending;   // rows remain for the loaded triangle
   } status_type;

endpackage

FILE: rtl/core/tssg_div.sv
// Iterative signed divider, one quotient bit per cycle while step is high; divisor is positive.
// Depends on nothing beyond its parameters.
module tssg_div #(
   parameter int C = 12
) (
   input  logic                  clock,
   input  logic                  init,
   input  logic                  step,
   input  logic signed [2*C+2:0] num,
   input  logic        [C-1:0]   den,
   output logic signed [C-1:0]   quot
);
   logic [C-1:0]   rem_ff, rem_in;
   logic [C-1:0]   sh_ff, sh_in;
   logic           neg_ff, neg_in;
   logic [2*C+2:0] mag;
   logic [C:0]     cat;
   logic [C:0]     diff;
   logic           ge;

   always_comb begin
      mag    = num[2*C+2] ? (~num + 1'b1) : num;
      cat    = {rem_ff, sh_ff[C-1]};
      ge     = cat >= {1'b0, den};
      diff   = cat - {1'b0, den};
      rem_in = rem_ff;
      sh_in  = sh_ff;
      neg_in = neg_ff;
      if (init) begin
         // quotient magnitude stays below 2^C, so the top part starts below den
         rem_in = mag[2*C-1:C];
         sh_in  = mag[C-1:0];
         neg_in = num[2*C+2];
      end else if (step) begin
         rem_in = ge ? diff[C-1:0] : cat[C-1:0];
         sh_in  = {sh_ff[C-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      neg_ff <= neg_in;
   end

   assign quot = neg_ff ? $signed(~sh_ff + 1'b1) : $signed(sh_ff);
endmodule

FILE: rtl/core/tssg_dp.sv
// Datapath: vertex store, row state, edge setup, two dividers, result register.
// Depends on tssg_pkg and tssg_div.
module tssg_dp import tssg_pkg::*; #(
   parameter int C = COORD_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic signed [C-1:0] req_ax,
   input  logic signed [C-1:0] req_ay,
   input  logic signed [C-1:0] req_bx,
   input  logic signed [C-1:0] req_by_coord,
   input  logic signed [C-1:0] req_cx,
   input  logic signed [C-1:0] req_cy,
   output logic signed [C-1:0] rsp_box_left,
   output logic signed [C-1:0] rsp_box_top,
   output logic        [C-1:0] rsp_box_width,
   output logic        [C-1:0] rsp_box_height,
   output logic                rsp_span_valid,
   output logic signed [C-1:0] rsp_span_row,
   output logic signed [C-1:0] rsp_span_start,
   output logic signed [C-1:0] rsp_span_end,
   output logic                rsp_last_span
);
   localparam int NW = 2 * C + 3;

   logic signed [C-1:0] vx_ff [3];
   logic signed [C-1:0] vy_ff [3];
   logic signed [C-1:0] row_ff, row_in;
   logic                pend_ff, pend_in;

   logic signed [C-1:0] lx, rx, ty, by;
   logic signed [C:0]   wdiff, hdiff;
   logic signed [C:0]   row_nx;
   logic                more_rows;

   // per-edge setup
   logic                hit [3];
   logic signed [C-1:0] ex1 [3];
   logic        [C-1:0] edy [3];
   logic signed [C:0]   edx [3];
   logic        [C-1:0] eyo [3];
   logic [1:0]          sel0, sel1;
   logic                none_in;

   logic signed [C-1:0] x1_ff  [2];
   logic        [C-1:0] dy_ff  [2];
   logic signed [C:0]   dx_ff  [2];
   logic        [C-1:0] yo_ff  [2];
   logic                none_ff;

   logic signed [2*C:0]   p0 [2];
   logic signed [2*C+1:0] p1 [2];
   logic signed [NW-1:0]  num [2];
   logic signed [C-1:0]   quo [2];
   logic signed [C-1:0]   xa, xb, sx, tx;

   logic signed [C-1:0] bl_ff, bt_ff, sr_ff, ss_ff, se_ff;
   logic        [C-1:0] bw_ff, bh_ff;
   logic                sv_ff, ls_ff;

   always_comb begin
      lx = vx_ff[0];
      rx = vx_ff[0];
      ty = vy_ff[0];
      by = vy_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (vx_ff[i] < lx) lx = vx_ff[i];
         if (vx_ff[i] > rx) rx = vx_ff[i];
         if (vy_ff[i] < ty) ty = vy_ff[i];
         if (vy_ff[i] > by) by = vy_ff[i];
      end
      wdiff     = {rx[C-1], rx} - {lx[C-1], lx};
      hdiff     = {by[C-1], by} - {ty[C-1], ty};
      row_nx    = {row_ff[C-1], row_ff} + 1'b1;
      more_rows = row_nx < $signed({by[C-1], by});
   end

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         logic signed [C-1:0] ax1, ay1, ax2, ay2;
         logic signed [C:0]   dyw, yow;
         if (vy_ff[(e + 1) % 3] < vy_ff[e]) begin
            ax1 = vx_ff[(e + 1) % 3]; ay1 = vy_ff[(e + 1) % 3];
            ax2 = vx_ff[e];           ay2 = vy_ff[e];
         end else begin
            ax1 = vx_ff[e];           ay1 = vy_ff[e];
            ax2 = vx_ff[(e + 1) % 3]; ay2 = vy_ff[(e + 1) % 3];
         end
         dyw    = {ay2[C-1], ay2} - {ay1[C-1], ay1};
         yow    = {row_ff[C-1], row_ff} - {ay1[C-1], ay1};
         hit[e] = (ay1 != ay2) && (row_ff >= ay1) && (row_ff < ay2);
         ex1[e] = ax1;
         edy[e] = dyw[C-1:0];
         edx[e] = {ax2[C-1], ax2} - {ax1[C-1], ax1};
         eyo[e] = yow[C-1:0];
      end
      none_in = 1'b0;
      priority if (hit[0]) begin
         sel0 = 2'd0;
         sel1 = hit[1] ? 2'd1 : (hit[2] ? 2'd2 : 2'd0);
      end else if (hit[1]) begin
         sel0 = 2'd1;
         sel1 = hit[2] ? 2'd2 : 2'd1;
      end else if (hit[2]) begin
         sel0 = 2'd2;
         sel1 = 2'd2;
      end else begin
         sel0    = 2'd0;
         sel1    = 2'd0;
         none_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         x1_ff[0] <= ex1[sel0]; dy_ff[0] <= edy[sel0];
         dx_ff[0] <= edx[sel0]; yo_ff[0] <= eyo[sel0];
         x1_ff[1] <= ex1[sel1]; dy_ff[1] <= edy[sel1];
         dx_ff[1] <= edx[sel1]; yo_ff[1] <= eyo[sel1];
         none_ff  <= none_in;
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      assign p0[l]  = x1_ff[l] * $signed({1'b0, dy_ff[l]});
      assign p1[l]  = dx_ff[l] * $signed({1'b0, yo_ff[l]});
      assign num[l] = {{2{p0[l][2*C]}}, p0[l]} + {p1[l][2*C+1], p1[l]};
      tssg_div #(.C(C)) u_div (
         .clock (clock),
         .init  (cmd.mul),
         .step  (cmd.step),
         .num   (num[l]),
         .den   (dy_ff[l]),
         .quot  (quo[l])
      );
   end

   always_comb begin
      xa = none_ff ? '0 : quo[0];
      xb = none_ff ? '0 : quo[1];
      sx = (xa > xb) ? xb : xa;
      tx = (xa > xb) ? xa : xb;
   end

   // row state
   always_comb begin
      row_in  = row_ff;
      pend_in = pend_ff;
      if (cmd.out_box) begin
         row_in  = ty;
         pend_in = by > ty;
      end else if (cmd.out_span) begin
         row_in  = row_nx[C-1:0];
         pend_in = more_rows;
      end
   end

   // vertex store and row state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
         end
         row_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            vx_ff[0] <= req_ax; vy_ff[0] <= req_ay;
            vx_ff[1] <= req_bx; vy_ff[1] <= req_by_coord;
            vx_ff[2] <= req_cx; vy_ff[2] <= req_cy;
         end
         row_ff  <= row_in;
         pend_ff <= pend_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_box || cmd.out_span || cmd.out_none) begin
         bl_ff <= cmd.out_box ? lx : '0;
         bt_ff <= cmd.out_box ? ty : '0;
         bw_ff <= cmd.out_box ? wdiff[C-1:0] : '0;
         bh_ff <= cmd.out_box ? hdiff[C-1:0] : '0;
         sv_ff <= cmd.out_span;
         sr_ff <= cmd.out_span ? row_ff : '0;
         ss_ff <= cmd.out_span ? sx : '0;
         se_ff <= cmd.out_span ? tx : '0;
         ls_ff <= cmd.out_span && !more_rows;
      end
   end

   assign status.pending = pend_ff;
   assign rsp_box_left   = bl_ff;
   assign rsp_box_top    = bt_ff;
   assign rsp_box_width  = bw_ff;
   assign rsp_box_height = bh_ff;
   assign rsp_span_valid = sv_ff;
   assign rsp_span_row   = sr_ff;
   assign rsp_span_start = ss_ff;
   assign rsp_span_end   = se_ff;
   assign rsp_last_span  = ls_ff;
endmodule

FILE: rtl/core/tssg_ctrl.sv
// Controller state machine: request/result handshakes and datapath sequencing.
// Depends on tssg_pkg.
module tssg_ctrl import tssg_pkg::*; #(
   parameter int C = COORD_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_opcode,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);
   localparam int CW = $clog2(C);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BOX   = 3'd1;
   localparam logic [2:0] S_SETUP = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_SPAN  = 3'd5;
   localparam logic [2:0] S_NONE  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rv_ff, rv_in;
   logic          accept, out_free, out_load;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rv_ff || !rsp_stall;
   // hold off requests in reset and while one is at work
   assign req_stall = reset || (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_LOAD) begin
                  cmd.load = 1'b1;
                  state_in = S_BOX;
               end else begin
                  state_in = status.pending ? S_SETUP : S_NONE;
               end
            end
         end
         S_BOX: begin
            if (out_free) begin
               cmd.out_box = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CW'(C - 1)) state_in = S_SPAN;
         end
         S_SPAN: begin
            if (out_free) begin
               cmd.out_span = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_NONE: begin
            if (out_free) begin
               cmd.out_none = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      out_load = cmd.out_box || cmd.out_span || cmd.out_none;
      rv_in    = out_load || (rv_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !(rv_ff && rsp_stall))
      else $error("result register overwritten while held");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("second beat taken while one is at work");
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |=> state_ff == S_DIV && cnt_ff == '0)
      else $error("divider did not start from zero");
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff <= CW'(C - 1))
      else $error("divider count overran");
endmodule

FILE: rtl/core/triangle_scanline_span_generator.sv
// Top level of the triangle scanline span generator.
// Depends on tssg_pkg, tssg_ctrl, tssg_dp (and tssg_div below it).
//
// Request channel (req_*): opcode 0 loads three vertices, opcode 1 asks
// for the fill span of the next row. Every request beat yields exactly one
// result beat on the rsp_* channel, in order.
// A load answers with the bounding box; the first step then returns the
// lowest row, and rows run up to but not including the highest vertex y.
// last_span marks the final row; further steps return an all-zero result.
// A load goes through the box state to its result; a step with rows left
// runs setup, numerator multiply, the divide (one quotient bit per cycle
// in two parallel restoring dividers) and result write; a step with no rows
// left goes straight to an all-zero result write. The divider iteration
// count sets the rate. One request is worked on at a time;
// req_stall is high in reset and from acceptance until the result is written.
// The result register lets a new request in while a result still waits.
// When the receiver stalls, the result holds and the next result waits in
// the controller until the register frees.
// Reset (synchronous, active high) clears the vertices, row and pending
// flag: no triangle is loaded and steps return zero results.
module triangle_scanline_span_generator import tssg_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic signed [COORD_BITS-1:0] req_ax,
   input  logic signed [COORD_BITS-1:0] req_ay,
   input  logic signed [COORD_BITS-1:0] req_bx,
   input  logic signed [COORD_BITS-1:0] req_by_coord,
   input  logic signed [COORD_BITS-1:0] req_cx,
   input  logic signed [COORD_BITS-1:0] req_cy,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_box_left,
   output logic signed [COORD_BITS-1:0] rsp_box_top,
   output logic        [COORD_BITS-1:0] rsp_box_width,
   output logic        [COORD_BITS-1:0] rsp_box_height,
   output logic                         rsp_span_valid,
   output logic signed [COORD_BITS-1:0] rsp_span_row,
   output logic signed [COORD_BITS-1:0] rsp_span_start,
   output logic signed [COORD_BITS-1:0] rsp_span_end,
   output logic                         rsp_last_span
);
   cmd_type    cmd;
   status_type status;

   // sequencing and both handshakes
   tssg_ctrl #(.C(COORD_BITS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // vertex store, edge math, dividers and result register
   tssg_dp #(.C(COORD_BITS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_ax         (req_ax),
      .req_ay         (req_ay),
      .req_bx         (req_bx),
      .req_by_coord   (req_by_coord),
      .req_cx         (req_cx),
      .req_cy         (req_cy),
      .rsp_box_left   (rsp_box_left),
      .rsp_box_top    (rsp_box_top),
      .rsp_box_width  (rsp_box_width),
      .rsp_box_height (rsp_box_height),
      .rsp_span_valid (rsp_span_valid),
      .rsp_span_row   (rsp_span_row),
      .rsp_span_start (rsp_span_start),
      .rsp_span_end   (rsp_span_end),
      .rsp_last_span  (rsp_last_span)
   );
endmodule

FILE: bench/triangle_scanline_span_generator_test.sv
// Testbench for the triangle scanline span generator: loads triangles, walks
// their rows and checks every result beat against a behavioral predictor.
// Depends on tssg_pkg and the triangle_scanline_span_generator RTL.
`timescale 1ns / 100ps

module triangle_scanline_span_generator_test;
   import tssg_pkg::*;

   localparam int CB = 12;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct packed {
      logic      opcode;
      coord_type ax, ay, bx, by, cx, cy;
   } raster_cmd_type;

   typedef struct packed {
      coord_type     box_left, box_top;
      logic [CB-1:0] box_width, box_height;
      logic          span_valid;
      coord_type     span_row, span_start, span_end;
      logic          last_span;
   } raster_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_opcode = 1'b0;
   coord_type req_ax = '0, req_ay = '0, req_bx = '0, req_by_coord = '0;
   coord_type req_cx = '0, req_cy = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   coord_type rsp_box_left, rsp_box_top;
   logic [CB-1:0] rsp_box_width, rsp_box_height;
   logic rsp_span_valid, rsp_last_span;
   coord_type rsp_span_row, rsp_span_start, rsp_span_end;

   triangle_scanline_span_generator #(.COORD_BITS(CB)) dut (.*);

   always #5 clock = ~clock;

   // Stimulus and expected result beats.
   raster_cmd_type pending_cmds[$];
   raster_rsp_type expected_rsps[$];

   // Predictor state: vertices, next row, rows-left flag.
   int tri_x[3], tri_y[3];
   int next_row;
   bit rows_left;

   int mismatches = 0;
   bit calm = 1'b0;        // no idling in the closing stretch
   bit hold_sender = 1'b0; // sender waits for all results
   int idle_cnt = 0;
   int stall_cnt = 0;
   int quiet_cycles = 0;

   // Crossing of edge (p,q) with row y, exact integer, truncate toward zero.
   function automatic bit edge_cross(int p, int q, int y, output int x);
      longint x1, y1, x2, y2, dx, dy, num;
      x1 = tri_x[p]; y1 = tri_y[p]; x2 = tri_x[q]; y2 = tri_y[q];
      x = 0;
      if (y1 == y2) return 1'b0;
      if (y2 < y1) begin
         x1 = tri_x[q]; y1 = tri_y[q]; x2 = tri_x[p]; y2 = tri_y[p];
      end
      if (y < y1 || y >= y2) return 1'b0;
      dx = x2 - x1;
      dy = y2 - y1;
      num = x1 * dy + dx * (y - y1);
      x = int'(num / dy);
      return 1'b1;
   endfunction

   function automatic raster_rsp_type predict_raster(raster_cmd_type c);
      raster_rsp_type r;
      int xs[3];
      int n, s, t, lx, rx, ty, by, xv, e;
      r = '0;
      n = 0;
      if (c.opcode == OP_LOAD) begin
         tri_x[0] = c.ax; tri_y[0] = c.ay;
         tri_x[1] = c.bx; tri_y[1] = c.by;
         tri_x[2] = c.cx; tri_y[2] = c.cy;
         lx = tri_x[0]; rx = lx; ty = tri_y[0]; by = ty;
         for (e = 1; e < 3; e++) begin
            if (tri_x[e] < lx) lx = tri_x[e];
            if (tri_x[e] > rx) rx = tri_x[e];
            if (tri_y[e] < ty) ty = tri_y[e];
            if (tri_y[e] > by) by = tri_y[e];
         end
         r.box_left = CB'(lx); r.box_top = CB'(ty);
         r.box_width = CB'(rx - lx); r.box_height = CB'(by - ty);
         next_row = ty;
         rows_left = by > ty;
      end else if (rows_left) begin
         for (e = 0; e < 3; e++)
            if (edge_cross(e, (e + 1) % 3, next_row, xv)) begin
               xs[n] = xv;
               n++;
            end
         if (n == 0) begin
            xs[0] = 0;
            n = 1;
         end
         s = xs[0];
         t = (n > 1) ? xs[1] : xs[0];
         if (s > t) begin
            xv = s; s = t; t = xv;
         end
         by = tri_y[0];
         for (e = 1; e < 3; e++) if (tri_y[e] > by) by = tri_y[e];
         r.span_valid = 1'b1;
         r.span_row = CB'(next_row);
         r.span_start = CB'(s);
         r.span_end = CB'(t);
         next_row++;
         rows_left = next_row < by;
         r.last_span = !rows_left;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   // Append one beat to the stimulus queue.
   task automatic add_cmd(raster_cmd_type c);
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   function automatic raster_cmd_type make_load(int ax, int ay, int bx, int by,
                                                int cx, int cy);
      raster_cmd_type c;
      c.opcode = OP_LOAD;
      c.ax = CB'(ax); c.ay = CB'(ay); c.bx = CB'(bx);
      c.by = CB'(by); c.cx = CB'(cx); c.cy = CB'(cy);
      return c;
   endfunction

   function automatic raster_cmd_type make_step();
      raster_cmd_type c;
      c = '0;
      c.opcode = OP_STEP;
      // random don't-care vertex bits so every input bit toggles
      c.ax = CB'($urandom); c.ay = CB'($urandom); c.bx = CB'($urandom);
      c.by = CB'($urandom); c.cx = CB'($urandom); c.cy = CB'($urandom);
      return c;
   endfunction

   function automatic int rand_coord(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // Queue a triangle and its row walk, sometimes overrunning past the end.
   task automatic queue_triangle(int span_rows, int steps_extra);
      int ax, ay, bx, by, cx, cy, k, rows;
      ax = rand_coord(-2048, 2047); bx = rand_coord(-2048, 2047);
      cx = rand_coord(-2048, 2047);
      ay = rand_coord(-2048, 2047 - span_rows);
      by = ay + int'($urandom_range(span_rows));
      cy = ay + int'($urandom_range(span_rows));
      if ($urandom_range(3) == 0) begin
         k = ay; ay = cy; cy = k;
      end
      add_cmd(make_load(ax, ay, bx, by, cx, cy));
      rows = ay; if (by > rows) rows = by; if (cy > rows) rows = cy;
      k = ay; if (by < k) k = by; if (cy < k) k = cy;
      rows = rows - k;
      for (k = 0; k < rows + steps_extra; k++) add_cmd(make_step());
   endtask

   // Acceptance flags sampled at the rising edge.
   bit req_taken = 1'b0;
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken)
         expected_rsps.insert(expected_rsps.size(),
                              predict_raster(pending_cmds.pop_front()));
   end

   // Driver: present beats at the falling edge, idle in random bursts.
   always @(negedge clock) begin
      raster_cmd_type c;
      if (!reset && (!req_valid || req_taken)) begin
         if (idle_cnt > 0) idle_cnt--;
         if (!calm && idle_cnt == 0 && $urandom_range(7) == 0)
            idle_cnt = $urandom_range(9, 1);
         if (pending_cmds.size() > 0 && idle_cnt == 0 &&
             !(hold_sender && expected_rsps.size() > 0)) begin
            c = pending_cmds[0];
            req_valid <= 1'b1;
            req_opcode <= c.opcode;
            req_ax <= c.ax; req_ay <= c.ay; req_bx <= c.bx;
            req_by_coord <= c.by; req_cx <= c.cx; req_cy <= c.cy;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall bursts, changed at the falling edge.
   always @(negedge clock) begin
      if (stall_cnt > 0) stall_cnt--;
      if (!calm && stall_cnt == 0 && $urandom_range(6) == 0)
         stall_cnt = $urandom_range(9, 1);
      rsp_stall <= (stall_cnt > 0);
   end

   // Monitor: compare each accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      raster_rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            w = expected_rsps.pop_front();
            if (rsp_box_left !== w.box_left)
               report_mismatch("box_left", rsp_box_left, w.box_left);
            if (rsp_box_top !== w.box_top)
               report_mismatch("box_top", rsp_box_top, w.box_top);
            if (rsp_box_width !== w.box_width)
               report_mismatch("box_width", rsp_box_width, w.box_width);
            if (rsp_box_height !== w.box_height)
               report_mismatch("box_height", rsp_box_height, w.box_height);
            if (rsp_span_valid !== w.span_valid)
               report_mismatch("span_valid", rsp_span_valid, w.span_valid);
            if (rsp_span_row !== w.span_row)
               report_mismatch("span_row", rsp_span_row, w.span_row);
            if (rsp_span_start !== w.span_start)
               report_mismatch("span_start", rsp_span_start, w.span_start);
            if (rsp_span_end !== w.span_end)
               report_mismatch("span_end", rsp_span_end, w.span_end);
            if (rsp_last_span !== w.last_span)
               report_mismatch("last_span", rsp_last_span, w.last_span);
         end
      end
   end

   // Watchdog: count cycles with no beat on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int k;
      // Directed: steps with nothing loaded, extremes, flat and degenerate shapes.
      add_cmd(make_step());
      add_cmd(make_step());
      add_cmd(make_load(-2048, -2048, 2047, 2047, -2048, 2047));
      add_cmd(make_step());
      add_cmd(make_step());
      add_cmd(make_load(5, 7, -3, 7, 100, 7));   // flat
      add_cmd(make_step());
      add_cmd(make_load(0, 0, 0, 3, 0, 1));      // zero width
      for (k = 0; k < 4; k++) add_cmd(make_step());
      add_cmd(make_load(-10, 2045, 10, 2047, 2047, 2045));
      for (k = 0; k < 3; k++) add_cmd(make_step());
      add_cmd(make_load(-2048, 0, 2047, 1, -7, 0));
      for (k = 0; k < 3; k++) add_cmd(make_step());

      repeat (7) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      wait (pending_cmds.size() == 0);
      // Sender pause until every prediction has been answered.
      hold_sender = 1'b1;
      for (k = 0; k < 4; k++) queue_triangle(6, 1);
      wait (pending_cmds.size() == 0 && expected_rsps.size() == 0);
      hold_sender = 1'b0;

      // Random triangles, mostly short, a few tall; some stray steps.
      while (pending_cmds.size() < 1250) begin
         if ($urandom_range(15) == 0)
            queue_triangle(200, 0);
         else
            queue_triangle(int'($urandom_range(30)), int'($urandom_range(2)));
         if ($urandom_range(9) == 0) add_cmd(make_step());
         if (pending_cmds.size() > 1400) break;
      end
      wait (pending_cmds.size() < 200);
      calm = 1'b1;
      wait (pending_cmds.size() == 0);
      wait (expected_rsps.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
